FILE: design/sage_pkg.sv
// ----------------------------------------------------------------------------
// sage_pkg
// Types and constants shared by the sample adaptive Golomb encoder.
// ----------------------------------------------------------------------------
package sage_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 6;

  localparam logic [CfgIdxW-1:0] REG_DYN_RANGE   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_UNARY_LIMIT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_COUNT_EXP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ACCUM_CONST = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RESCALE_EXP = 3'd4;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               band_start;
    logic               image_end;
  } sage_in_t;

  typedef struct packed {
    logic [WordW-1:0] code_word;
    logic             run_last;
    logic             stream_done;
  } sage_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_RIGHT,
    S_KSRCH,
    S_ZEROS,
    S_TAIL,
    S_FIN,
    S_DONE
  } sage_state_e;

endpackage

FILE: design/sample_adaptive_golomb_encoder.sv
// ----------------------------------------------------------------------------
// sample_adaptive_golomb_encoder
// Adaptive Golomb power-of-two coder packing codewords into 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one mapped
//   residual per transaction. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns 0 to 3 packed words per sample; run_last marks the
//   last word of a sample and stream_done the final word of an image.
//   Config channel (cfg_valid_i / cfg_ready_o) writes a register by index;
//   write only while the block is idle.
//   A coded sample passes update, right, k search, unary zeros, tail, fin
//   and done; k, the chosen Golomb parameter, is at most D-2. A band-start
//   sample goes straight to tail. The k search is a single shift-and-compare
//   unit iterated once per candidate, and all appends use one 64-bit shifter.
//   One sample is in flight at a time; in_stall_o is high until its last
//   word has been handed to the output register.
//   A stalled receiver holds the output register; the coder waits when both
//   the output register and its internal word holding stage are full.
//   Reset: registers return to defaults, the bit buffer is empty and the
//   statistics reload on the first sample of the next image.
// ----------------------------------------------------------------------------
module sample_adaptive_golomb_encoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sage_pkg::sage_in_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sage_pkg::sage_out_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [sage_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sage_pkg::CfgDatW-1:0]    cfg_data_i
);

  // configuration registers
  logic [4:0] dyn_q;
  logic [5:0] ul_q;
  logic [3:0] ce_q;
  logic [3:0] kc_q;
  logic [3:0] g_q;

  // effective settings
  logic [4:0]  d_eff;
  logic [5:0]  ul_eff;
  logic [3:0]  g_eff;
  logic [3:0]  ce_eff;
  logic [3:0]  kc_eff;
  logic [3:0]  kmax;
  logic [10:0] limit;
  logic [21:0] acc_base;
  logic [29:0] acc_prod;
  logic [31:0] acc_init;
  logic [10:0] cnt_init;
  logic [16:0] d_mask;

  sage_pkg::sage_state_e state_q, state_d;

  logic        open_q, open_d;
  logic [31:0] acc_q, acc_d;
  logic [10:0] cnt_q, cnt_d;
  logic [15:0] prev_q, prev_d;
  logic [63:0] buf_q, buf_d;
  logic [4:0]  pend_q, pend_d;
  logic [15:0] s_q, s_d;
  logic        last_q, last_d;
  logic        esc_q, esc_d;
  logic [3:0]  k_q, k_d;
  logic [32:0] right_q, right_d;

  logic        hold_v_q, hold_v_d;
  logic        hold_sd_q, hold_sd_d;
  logic [31:0] hold_w_q, hold_w_d;

  logic                out_valid_q, out_valid_d;
  sage_pkg::sage_out_t out_q, out_d;

  logic        in_acc;
  logic        out_free;
  logic        can_emit;
  logic [31:0] app_val;
  logic [5:0]  app_n;
  logic [32:0] app_mask;
  logic [63:0] app_cat;
  logic [5:0]  pend_sum;
  logic        emit_need;
  logic        app_ok;
  logic [31:0] emit_word;
  logic [31:0] flush_word;
  logic        fin_ok;
  logic        done_ok;
  logic [32:0] cnt_sh;
  logic        k_more;
  logic [15:0] q_val;
  logic        q_lt;
  logic [5:0]  u_val;
  logic [11:0] cnt_inc;
  logic [32:0] acc_sum;
  logic [16:0] cnt_mul;

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dyn_q <= 5'd16;
      ul_q  <= 6'd18;
      ce_q  <= 4'd1;
      kc_q  <= 4'd1;
      g_q   <= 4'd6;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sage_pkg::REG_DYN_RANGE:   dyn_q <= cfg_data_i[4:0];
        sage_pkg::REG_UNARY_LIMIT: ul_q  <= cfg_data_i;
        sage_pkg::REG_COUNT_EXP:   ce_q  <= cfg_data_i[3:0];
        sage_pkg::REG_ACCUM_CONST: kc_q  <= cfg_data_i[3:0];
        sage_pkg::REG_RESCALE_EXP: g_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dyn_q == 5'd0 || dyn_q > 5'd16) begin
      d_eff = 5'd16;
    end else if (dyn_q < 5'd2) begin
      d_eff = 5'd2;
    end else begin
      d_eff = dyn_q;
    end
    ul_eff = (ul_q > 6'd32) ? 6'd32 : ul_q;
    if (g_q < 4'd4) begin
      g_eff = 4'd4;
    end else if (g_q > 4'd11) begin
      g_eff = 4'd11;
    end else begin
      g_eff = g_q;
    end
    if (ce_q < 4'd1) begin
      ce_eff = 4'd1;
    end else if (ce_q > 4'd8) begin
      ce_eff = 4'd8;
    end else begin
      ce_eff = ce_q;
    end
    kc_eff = (kc_q > 4'd14) ? 4'd14 : kc_q;
  end

  assign kmax     = 4'(d_eff - 5'd2);
  assign limit    = 11'((12'd1 << g_eff) - 12'd1);
  assign acc_base = (22'd3 << (5'(kc_eff) + 5'd6)) - 22'd49;
  assign acc_prod = 30'(acc_base) << ce_eff;
  assign acc_init = 32'(acc_prod >> 7);
  assign cnt_init = 11'(11'd1 << ce_eff);
  assign d_mask   = (17'd1 << d_eff) - 17'd1;

  // handshakes
  assign in_stall_o  = (state_q != sage_pkg::S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign can_emit    = !hold_v_q || out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // k search and unary length
  assign cnt_sh  = 33'(cnt_q) << (5'(k_q) + 5'd1);
  assign k_more  = (k_q < kmax) && (cnt_sh <= right_q);
  assign q_val   = s_q >> k_q;
  assign q_lt    = (q_val < 16'(ul_eff));
  assign u_val   = q_lt ? q_val[5:0] : ul_eff;
  assign cnt_inc = 12'(cnt_q) + 12'd1;
  assign acc_sum = 33'(acc_q) + 33'(prev_q);
  assign cnt_mul = 17'd49 * 17'(cnt_q);

  // bit packer
  always_comb begin
    if (state_q == sage_pkg::S_ZEROS) begin
      app_val = 32'd0;
      app_n   = u_val;
    end else if (esc_q) begin
      app_val = 32'(s_q);
      app_n   = 6'(d_eff);
    end else begin
      app_val = (32'd1 << k_q) | 32'(s_q & 16'((17'd1 << k_q) - 17'd1));
      app_n   = 6'(k_q) + 6'd1;
    end
  end

  assign app_mask   = (33'd1 << app_n) - 33'd1;
  assign app_cat    = (buf_q << app_n) | 64'(app_val & app_mask[31:0]);
  assign pend_sum   = 6'(pend_q) + app_n;
  assign emit_need  = pend_sum[5];
  assign app_ok     = !emit_need || can_emit;
  assign emit_word  = 32'(app_cat >> pend_sum[4:0]);
  assign flush_word = buf_q[31:0] << (6'd32 - 6'(pend_q));
  assign fin_ok     = !(last_q && pend_q != 5'd0) || can_emit;
  assign done_ok    = !hold_v_q || out_free;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sage_pkg::S_IDLE: begin
        if (in_acc) begin
          state_d = in_data_i.band_start ? sage_pkg::S_TAIL : sage_pkg::S_UPDATE;
        end
      end
      sage_pkg::S_UPDATE: state_d = sage_pkg::S_RIGHT;
      sage_pkg::S_RIGHT:  state_d = sage_pkg::S_KSRCH;
      sage_pkg::S_KSRCH: begin
        if (!k_more) state_d = sage_pkg::S_ZEROS;
      end
      sage_pkg::S_ZEROS: begin
        if (app_ok) state_d = sage_pkg::S_TAIL;
      end
      sage_pkg::S_TAIL: begin
        if (app_ok) state_d = sage_pkg::S_FIN;
      end
      sage_pkg::S_FIN: begin
        if (fin_ok) state_d = sage_pkg::S_DONE;
      end
      sage_pkg::S_DONE: begin
        if (done_ok) state_d = sage_pkg::S_IDLE;
      end
      default: state_d = sage_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    open_d      = open_q;
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    buf_d       = buf_q;
    pend_d      = pend_q;
    s_d         = s_q;
    last_d      = last_q;
    esc_d       = esc_q;
    k_d         = k_q;
    right_d     = right_q;
    hold_v_d    = hold_v_q;
    hold_sd_d   = hold_sd_q;
    hold_w_d    = hold_w_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    case (state_q)
      sage_pkg::S_IDLE: begin
        if (in_acc) begin
          s_d    = in_data_i.sample & d_mask[15:0];
          last_d = in_data_i.image_end;
          esc_d  = 1'b1;
          if (!open_q) begin
            open_d = 1'b1;
            acc_d  = acc_init;
            cnt_d  = cnt_init;
            prev_d = 16'd0;
          end
        end
      end
      sage_pkg::S_UPDATE: begin
        if (cnt_q < limit) begin
          acc_d = acc_sum[31:0];
          cnt_d = cnt_inc[10:0];
        end else begin
          acc_d = 32'((acc_sum + 33'd1) >> 1);
          cnt_d = 11'(cnt_inc >> 1);
        end
      end
      sage_pkg::S_RIGHT: begin
        right_d = 33'(acc_q) + 33'(cnt_mul >> 7);
        k_d     = 4'd0;
      end
      sage_pkg::S_KSRCH: begin
        if (k_more) k_d = k_q + 4'd1;
        esc_d = !q_lt;
      end
      sage_pkg::S_ZEROS, sage_pkg::S_TAIL: begin
        if (app_ok) begin
          buf_d  = app_cat;
          pend_d = pend_sum[4:0];
          if (emit_need) begin
            if (hold_v_q) begin
              out_valid_d = 1'b1;
              out_d       = '{code_word: hold_w_q, run_last: 1'b0, stream_done: 1'b0};
            end
            hold_v_d  = 1'b1;
            hold_sd_d = 1'b0;
            hold_w_d  = emit_word;
          end
        end
      end
      sage_pkg::S_FIN: begin
        if (fin_ok) begin
          prev_d = s_q;
          if (last_q) begin
            open_d = 1'b0;
            buf_d  = 64'd0;
            pend_d = 5'd0;
            if (pend_q != 5'd0) begin
              if (hold_v_q) begin
                out_valid_d = 1'b1;
                out_d       = '{code_word: hold_w_q, run_last: 1'b0, stream_done: 1'b0};
              end
              hold_v_d  = 1'b1;
              hold_sd_d = 1'b1;
              hold_w_d  = flush_word;
            end else begin
              hold_sd_d = 1'b1;
            end
          end
        end
      end
      sage_pkg::S_DONE: begin
        if (hold_v_q && out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{code_word: hold_w_q, run_last: 1'b1, stream_done: hold_sd_q};
          hold_v_d    = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sage_pkg::S_IDLE;
      open_q      <= 1'b0;
      buf_q       <= 64'd0;
      pend_q      <= 5'd0;
      prev_q      <= 16'd0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      buf_q       <= buf_d;
      pend_q      <= pend_d;
      prev_q      <= prev_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    cnt_q     <= cnt_d;
    s_q       <= s_d;
    last_q    <= last_d;
    esc_q     <= esc_d;
    k_q       <= k_d;
    right_q   <= right_d;
    hold_sd_q <= hold_sd_d;
    hold_w_q  <= hold_w_d;
    out_q     <= out_d;
  end

`ifndef SYNTH
  a_idle_hold_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !hold_v_q)
    else $error("word left in holding stage while idle");

  a_k_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sage_pkg::S_ZEROS) |-> (k_q <= kmax))
    else $error("k above D-2");

  a_cnt_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sage_pkg::S_RIGHT) |-> (cnt_q != 11'd0))
    else $error("counter reached zero");

  a_last_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sage_pkg::S_DONE && hold_v_q && out_free)
      |=> (out_valid_o && out_data_o.run_last))
    else $error("final word of sample not marked");
`endif

endmodule
